### hw/rtl/ked_pkg.sv
// Shared types, constants and helper tables for the knob event decoder.
package ked_pkg;

	localparam int DETENT_STEP_DEF = 4;
	localparam int COUNT_BITS_DEF  = 8;
	localparam int POS_W           = 8;
	localparam int PUSH_W          = 7;
	localparam int CODE_W          = 3;
	localparam int THR_W           = 8;
	localparam int POS_SPAN        = 1 << POS_W;

	localparam logic [THR_W-1:0] THR_RESET = 8'd128;

	typedef enum logic [CODE_W-1:0] {
		EV_NONE       = 3'd0,
		EV_GREEN_UP   = 3'd1,
		EV_RED_UP     = 3'd2,
		EV_GREEN_DOWN = 3'd3,
		EV_RED_DOWN   = 3'd4,
		EV_PAIR_PRESS = 3'd5,
		EV_BLUE_PRESS = 3'd6
	} event_code_t;

	typedef enum logic {
		MODE_INIT   = 1'b0,
		MODE_SAMPLE = 1'b1
	} mode_t;

	// One bit per possible 8-bit position: set where the position sits on a detent.
	function automatic logic [POS_SPAN-1:0] detent_table(input int step);
		logic [POS_SPAN-1:0] t;
		t = '0;
		for (int k = 0; k < POS_SPAN; k += step) begin
			t[k] = 1'b1;
		end
		return t;
	endfunction

endpackage

### hw/rtl/knob_event_decoder.sv
// Knob event decoder: turns knob position and push samples into event codes.
// An accepted item passes the input register, then the result register, before its event code shows.
// Throughput: one item per cycle while out_ready is high; the only loop is the previous-position
// and held-flag update, which closes within the single decode stage between the two registers.
// Reset (arst_n low, asynchronous): both stages empty, stored positions zero, held flags clear,
// wrap threshold back to 128.
module knob_event_decoder
	import ked_pkg::*;
#(
	parameter int DETENT_STEP = DETENT_STEP_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration: the wrap threshold register.
	input  logic              cfg_wr_en,
	input  logic [THR_W-1:0]  cfg_wr_data,
	// Input items.
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              mode,
	input  logic [POS_W-1:0]  red_position,
	input  logic [POS_W-1:0]  green_position,
	input  logic              blue_pushed,
	input  logic [PUSH_W-1:0] other_push_bits,
	// Result items.
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CODE_W-1:0] event_code
);

	// The comparison width covers both the stored count and the 8-bit threshold.
	localparam int DIFF_W = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

	// Positions are masked to the count width before anything else looks at them.
	localparam logic [POS_W-1:0] POS_MASK =
		(COUNT_BITS >= POS_W) ? {POS_W{1'b1}} : POS_W'((1 << COUNT_BITS) - 1);

	localparam logic [POS_SPAN-1:0] DETENT_HIT = detent_table(DETENT_STEP);

	typedef struct packed {
		logic hit;
		logic up;
	} knob_res_t;

	// Input stage.
	logic              valid_s1;
	logic              mode_s1;
	logic [POS_W-1:0]  red_s1;
	logic [POS_W-1:0]  green_s1;
	logic              blue_s1;
	logic              pair_s1;

	// Decoder state.
	logic [THR_W-1:0]      wrap_threshold_q;
	logic [COUNT_BITS-1:0] last_red_q;
	logic [COUNT_BITS-1:0] last_green_q;
	logic                  blue_held_q;
	logic                  pair_held_q;

	// Result stage.
	logic              valid_s2;
	logic [CODE_W-1:0] code_s2;

	// Decode outputs.
	logic                  advance;
	knob_res_t             red_res;
	knob_res_t             green_res;
	event_code_t           code_d;
	logic [COUNT_BITS-1:0] last_red_d;
	logic [COUNT_BITS-1:0] last_green_d;
	logic                  blue_held_d;
	logic                  pair_held_d;

	// A knob counts when it moved onto a detent. A difference below the threshold is taken
	// at face value; anything else is read as a wrap and the direction flips.
	function automatic knob_res_t knob_check(
		input logic [POS_W-1:0]      now8,
		input logic [COUNT_BITS-1:0] prev,
		input logic [THR_W-1:0]      thr
	);
		logic [COUNT_BITS+POS_W-1:0] ext;
		logic [COUNT_BITS-1:0]       now;
		logic [DIFF_W-1:0]           now_w;
		logic [DIFF_W-1:0]           prev_w;
		logic [DIFF_W-1:0]           diff;
		logic                        rising;
		logic                        small_step;
		knob_res_t                   r;
		ext        = {{COUNT_BITS{1'b0}}, now8};
		now        = ext[COUNT_BITS-1:0];
		now_w      = DIFF_W'(now);
		prev_w     = DIFF_W'(prev);
		rising     = now_w > prev_w;
		diff       = rising ? (now_w - prev_w) : (prev_w - now_w);
		small_step = diff < DIFF_W'(thr);
		r.hit      = (now != prev) && DETENT_HIT[now8];
		r.up       = rising ? small_step : !small_step;
		return r;
	endfunction

	// The input stage moves on whenever the result register is free or being emptied.
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		logic [COUNT_BITS+POS_W-1:0] red_ext;
		logic [COUNT_BITS+POS_W-1:0] green_ext;
		red_ext      = {{COUNT_BITS{1'b0}}, red_s1};
		green_ext    = {{COUNT_BITS{1'b0}}, green_s1};
		red_res      = knob_check(red_s1, last_red_q, wrap_threshold_q);
		green_res    = knob_check(green_s1, last_green_q, wrap_threshold_q);
		code_d       = EV_NONE;
		last_red_d   = last_red_q;
		last_green_d = last_green_q;
		blue_held_d  = blue_held_q;
		pair_held_d  = pair_held_q;
		priority if (mode_s1 == MODE_INIT) begin
			// Init item: take the sampled positions as reference and forget held pushes.
			last_red_d   = red_ext[COUNT_BITS-1:0];
			last_green_d = green_ext[COUNT_BITS-1:0];
			blue_held_d  = 1'b0;
			pair_held_d  = 1'b0;
		end else if (red_res.hit) begin
			code_d     = red_res.up ? EV_RED_UP : EV_RED_DOWN;
			last_red_d = red_ext[COUNT_BITS-1:0];
		end else if (green_res.hit) begin
			code_d       = green_res.up ? EV_GREEN_UP : EV_GREEN_DOWN;
			last_green_d = green_ext[COUNT_BITS-1:0];
		end else if (blue_s1 && !blue_held_q) begin
			// New blue press wins; the red/green push is left for a later sample.
			code_d      = EV_BLUE_PRESS;
			blue_held_d = 1'b1;
		end else begin
			// Blue is either held (no event) or released; the red/green push is checked next.
			blue_held_d = blue_s1;
			if (pair_s1 && !pair_held_q) begin
				code_d = EV_PAIR_PRESS;
			end
			pair_held_d = pair_s1;
		end
	end

	// Input stage registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1  <= mode;
			red_s1   <= red_position & POS_MASK;
			green_s1 <= green_position & POS_MASK;
			blue_s1  <= blue_pushed;
			pair_s1  <= |other_push_bits;
		end
	end

	// Decoder state: the threshold follows cfg writes; the rest updates as each item leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_threshold_q <= THR_RESET;
			last_red_q       <= '0;
			last_green_q     <= '0;
			blue_held_q      <= 1'b0;
			pair_held_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				wrap_threshold_q <= cfg_wr_data;
			end
			if (valid_s1 && advance) begin
				last_red_q   <= last_red_d;
				last_green_q <= last_green_d;
				blue_held_q  <= blue_held_d;
				pair_held_q  <= pair_held_d;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			code_s2 <= code_d;
		end
	end

	assign out_valid  = valid_s2;
	assign event_code = code_s2;

endmodule

### hw/rtl/ked_checker.sv
// Port-level checker for the knob event decoder, bound to the top level.
module ked_checker
	import ked_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CODE_W-1:0] event_code
);

	// A stalled result keeps its code.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_code))
		else $error("result changed while stalled");

	// With the result register empty, the block never pushes back on its input.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// A newly shown result comes from an item accepted through the input register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching input item");

	// Only defined event codes are ever shown.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_code <= CODE_W'(EV_BLUE_PRESS))
		else $error("undefined event code");

endmodule

bind knob_event_decoder ked_checker u_ked_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.event_code (event_code)
);
